>>> rtl/isf_pkg.sv
// shared constants, types and the chromaticity table of the image format sniffer
package isf_pkg;

	localparam logic [2:0] KIND_UNKNOWN = 3'd0;
	localparam logic [2:0] KIND_EXR     = 3'd1;
	localparam logic [2:0] KIND_PNG     = 3'd2;
	localparam logic [2:0] KIND_JPEG    = 3'd3;
	localparam logic [2:0] KIND_HDR     = 3'd4;

	localparam logic [31:0] EXR_MAGIC_A = 32'h0131_2F76;
	localparam logic [31:0] EXR_MAGIC_B = 32'h762F_3101;

	localparam logic [31:0] ID_SRGB = 32'h7352_4742;
	localparam logic [31:0] ID_GAMA = 32'h6741_4D41;
	localparam logic [31:0] ID_CHRM = 32'h6348_524D;

	localparam logic [31:0] GAMMA_LOW  = 32'd45452;
	localparam logic [31:0] GAMMA_HIGH = 32'd45457;

	typedef struct packed {
		logic [2:0] kind;
		logic       lin;
		logic       is_png;
	} isf_magic_t;

	// one byte of the big-endian srgb chromaticity words, by data byte index
	function automatic logic [7:0] chrm_byte(input logic [4:0] idx);
		logic [31:0] word;
		begin
			unique case (idx[4:2])
				3'd0: word = 32'd31270;
				3'd1: word = 32'd32900;
				3'd2: word = 32'd64000;
				3'd3: word = 32'd33000;
				3'd4: word = 32'd30000;
				3'd5: word = 32'd60000;
				3'd6: word = 32'd15000;
				default: word = 32'd6000;
			endcase
			unique case (idx[1:0])
				2'd0: chrm_byte = word[31:24];
				2'd1: chrm_byte = word[23:16];
				2'd2: chrm_byte = word[15:8];
				default: chrm_byte = word[7:0];
			endcase
		end
	endfunction

endpackage

>>> rtl/isf_magic.sv
// leading byte capture and magic number checks
module isf_magic (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              beat,
	input  logic [7:0]        data_byte,
	input  logic              last_byte,
	output logic              chunk_en,
	output isf_pkg::isf_magic_t magic
);
	import isf_pkg::*;

	localparam logic [3:0] HEAD_DEPTH = 4'd10;

	logic [7:0] head_q  [HEAD_DEPTH];
	logic [7:0] head_nx [HEAD_DEPTH];
	logic [3:0] pos_q;
	logic [3:0] pos_nx;
	logic [31:0] exr_word;
	logic is_exr, is_png, is_jpeg, is_hdr;

	assign chunk_en = (pos_q >= 4'd8);
	assign pos_nx   = (pos_q < HEAD_DEPTH) ? pos_q + 4'd1 : pos_q;

	always_comb begin
		for (int i = 0; i < HEAD_DEPTH; i++) begin
			head_nx[i] = head_q[i];
		end
		if (pos_q < HEAD_DEPTH) begin
			head_nx[pos_q] = data_byte;
		end
	end

	assign exr_word = {head_nx[3], head_nx[2], head_nx[1], head_nx[0]};
	assign is_exr = (pos_nx >= 4'd4) && (exr_word == EXR_MAGIC_A || exr_word == EXR_MAGIC_B);
	assign is_png = (pos_nx >= 4'd8) && head_nx[0] == 8'h89 && head_nx[1] == 8'h50 &&
		head_nx[2] == 8'h4E && head_nx[3] == 8'h47 && head_nx[4] == 8'h0D &&
		head_nx[5] == 8'h0A && head_nx[6] == 8'h1A && head_nx[7] == 8'h0A;
	assign is_jpeg = (pos_nx >= 4'd3) && head_nx[0] == 8'hFF && head_nx[1] == 8'hD8 &&
		head_nx[2] == 8'hFF;
	// "#?RGBE" or "#?RADIANCE"
	assign is_hdr = (pos_nx >= HEAD_DEPTH) && head_nx[0] == 8'h23 && head_nx[1] == 8'h3F &&
		head_nx[2] == 8'h52 &&
		((head_nx[3] == 8'h47 && head_nx[4] == 8'h42 && head_nx[5] == 8'h45) ||
		 (head_nx[3] == 8'h41 && head_nx[4] == 8'h44 && head_nx[5] == 8'h49 &&
		  head_nx[6] == 8'h41 && head_nx[7] == 8'h4E && head_nx[8] == 8'h43 &&
		  head_nx[9] == 8'h45));

	always_comb begin
		magic = '0;
		priority if (is_exr) begin
			magic.kind = KIND_EXR;
			magic.lin  = 1'b1;
		end else if (is_png) begin
			magic.kind   = KIND_PNG;
			magic.is_png = 1'b1;
		end else if (is_jpeg) begin
			magic.kind = KIND_JPEG;
		end else if (is_hdr) begin
			magic.kind = KIND_HDR;
			magic.lin  = 1'b1;
		end else begin
			magic.kind = KIND_UNKNOWN;
		end
	end

	always_ff @(posedge clk) begin
		if (beat) begin
			head_q <= head_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (beat) begin
			pos_q <= last_byte ? 4'd0 : pos_nx;
		end
	end

endmodule

>>> rtl/isf_chunk_walk.sv
// png chunk walker: tracks srgb, gama and chrm chunks after the signature
module isf_chunk_walk (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       beat,
	input  logic       chunk_en,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output logic       png_srgb
);
	import isf_pkg::*;

	localparam logic [1:0] PH_LEN   = 2'd0;
	localparam logic [1:0] PH_IDENT = 2'd1;
	localparam logic [1:0] PH_DATA  = 2'd2;

	logic [1:0]  phase_q, phase_nx;
	logic [32:0] cnt_q, cnt_nx, cnt_p1;
	logic [31:0] len_q, len_nx;
	logic [31:0] ident_q, ident_nx;
	logic [31:0] gamma_q, gamma_nx;
	logic seen_q, seen_nx, match_q, match_nx;
	logic found_q, found_nx, pend_q, pend_nx;
	logic [7:0] want;
	logic chunk_end, complete;

	assign cnt_p1    = cnt_q + 33'd1;
	assign chunk_end = (cnt_p1 >= ({1'b0, len_q} + 33'd4));
	assign want      = chrm_byte(cnt_q[4:0]);

	always_comb begin
		phase_nx = phase_q;
		cnt_nx   = cnt_q;
		len_nx   = len_q;
		ident_nx = ident_q;
		gamma_nx = gamma_q;
		seen_nx  = seen_q;
		match_nx = match_q;
		found_nx = found_q;
		pend_nx  = pend_q;
		if (chunk_en) begin
			unique case (phase_q)
				PH_IDENT: begin
					ident_nx = (cnt_q == '0) ? {24'd0, data_byte} : {ident_q[23:0], data_byte};
					if (cnt_q >= 33'd3) begin
						phase_nx = PH_DATA;
						cnt_nx   = '0;
						pend_nx  = (ident_nx == ID_SRGB);
					end else begin
						cnt_nx = cnt_p1;
					end
				end
				PH_DATA: begin
					if (pend_q) begin
						found_nx = 1'b1;
					end
					pend_nx = 1'b0;
					if (ident_q == ID_GAMA && cnt_q < 33'd4) begin
						gamma_nx = (cnt_q == '0) ? {24'd0, data_byte} : {gamma_q[23:0], data_byte};
					end
					if (ident_q == ID_CHRM && cnt_q < 33'd32) begin
						if (cnt_q == '0) begin
							seen_nx  = 1'b1;
							match_nx = (data_byte == want);
						end else if (data_byte != want) begin
							match_nx = 1'b0;
						end
					end
					if (chunk_end) begin
						// chrm chunk too short to hold all eight words
						if (ident_q == ID_CHRM && cnt_p1 < 33'd32) begin
							match_nx = 1'b0;
						end
						phase_nx = PH_LEN;
						cnt_nx   = '0;
					end else begin
						cnt_nx = cnt_p1;
					end
				end
				default: begin
					len_nx = (cnt_q == '0) ? {24'd0, data_byte} : {len_q[23:0], data_byte};
					if (cnt_q >= 33'd3) begin
						phase_nx = PH_IDENT;
						cnt_nx   = '0;
					end else begin
						phase_nx = PH_LEN;
						cnt_nx   = cnt_p1;
					end
				end
			endcase
		end
	end

	// file ending inside a chrm chunk's table means no match
	assign complete = match_nx &&
		!(phase_nx == PH_DATA && ident_nx == ID_CHRM && cnt_nx < 33'd32);
	assign png_srgb = found_nx ||
		(gamma_nx > GAMMA_LOW && gamma_nx < GAMMA_HIGH && seen_nx && complete);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEN;
			cnt_q   <= '0;
			len_q   <= '0;
			ident_q <= '0;
			gamma_q <= '0;
			seen_q  <= 1'b0;
			match_q <= 1'b0;
			found_q <= 1'b0;
			pend_q  <= 1'b0;
		end else if (beat) begin
			if (last_byte) begin
				phase_q <= PH_LEN;
				cnt_q   <= '0;
				len_q   <= '0;
				ident_q <= '0;
				gamma_q <= '0;
				seen_q  <= 1'b0;
				match_q <= 1'b0;
				found_q <= 1'b0;
				pend_q  <= 1'b0;
			end else begin
				phase_q <= phase_nx;
				cnt_q   <= cnt_nx;
				len_q   <= len_nx;
				ident_q <= ident_nx;
				gamma_q <= gamma_nx;
				seen_q  <= seen_nx;
				match_q <= match_nx;
				found_q <= found_nx;
				pend_q  <= pend_nx;
			end
		end
	end

endmodule

>>> rtl/image_format_sniffer_unit.sv
// top level of the image format sniffer: input stage, checks and result register
//
// channel   dir  tdata bits (low first)                          tlast
// s_axis    in   data_byte[7:0]                                   last_byte
// m_axis    out  recognized[0], file_kind[3:1], color_space[4]    -
//
// one byte per cycle but for the stall below; each byte is registered in the input stage, and the result
// of a file appears on m_axis the cycle after its last byte leaves that stage.
// non-last bytes never stall; a last byte waits in the input stage only while
// an earlier result is still held on m_axis.
// reset clears the input stage valid, the result valid and the file tracking state but for the captured head bytes.
module image_format_sniffer_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // data_byte[7:0]
	input  logic       s_axis_tlast,
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata    // recognized, file_kind[2:0], color_space, zero pad
);
	import isf_pkg::*;

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       last_s1;
	logic       adv;
	logic       chunk_en;
	logic       png_srgb;
	isf_magic_t magic;
	logic [2:0] kind_q;
	logic       lin_q;

	assign adv = valid_s1 && (!last_s1 || !m_axis_tvalid || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			data_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	isf_magic u_magic (
		.clk       (clk),
		.arst_n    (arst_n),
		.beat      (adv),
		.data_byte (data_s1),
		.last_byte (last_s1),
		.chunk_en  (chunk_en),
		.magic     (magic)
	);

	isf_chunk_walk u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.beat      (adv),
		.chunk_en  (chunk_en),
		.data_byte (data_s1),
		.last_byte (last_s1),
		.png_srgb  (png_srgb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (adv && last_s1) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			kind_q <= magic.kind;
			lin_q  <= magic.is_png ? !png_srgb : magic.lin;
		end
	end

	assign m_axis_tdata = {3'b000, lin_q, kind_q, (kind_q != KIND_UNKNOWN)};

	// a result only ever follows a last byte leaving the input stage
	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(adv && last_s1))
		else $error("result appeared without a last byte");

	// input stalls only behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (valid_s1 && last_s1 && m_axis_tvalid && !m_axis_tready))
		else $error("input stalled without a pending result");

	// a presented result carries a defined kind code
	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (kind_q == KIND_UNKNOWN || kind_q == KIND_EXR || kind_q == KIND_PNG ||
			kind_q == KIND_JPEG || kind_q == KIND_HDR))
		else $error("result kind out of range");

	// unknown and jpeg files are always reported as srgb
	a_srgb_kinds: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (kind_q == KIND_UNKNOWN || kind_q == KIND_JPEG)) |-> !lin_q)
		else $error("unknown or jpeg result marked linear");

endmodule

>>> verif/image_format_sniffer_unit_tb.sv
// testbench for image_format_sniffer_unit: random image files against a file verdict predictor
`timescale 1ns / 1ps

module image_format_sniffer_unit_tb;
	import isf_pkg::*;

	localparam bit SPACE_SRGB   = 1'b0;
	localparam bit SPACE_LINEAR = 1'b1;

	localparam bit [63:0] PNG_SIG   = 64'h8950_4E47_0D0A_1A0A;
	localparam bit [79:0] HDR_LONG  = "#?RADIANCE";
	localparam bit [47:0] HDR_SHORT = "#?RGBE";

	typedef enum logic [1:0] {WALK_LENGTH, WALK_IDENT, WALK_DATA} walk_phase_t;

	typedef struct packed {
		logic       recognized;
		logic [2:0] kind;
		logic       color_space;
	} file_verdict_t;

	class file_verdicts_t;
		bit [7:0]        head [10];
		int unsigned     seen;
		walk_phase_t     phase;
		longint unsigned pos;
		bit [31:0]       chunk_len;
		bit [31:0]       ident;
		bit [31:0]       gamma;
		bit              chrm_seen;
		bit              chrm_ok;
		bit              srgb_hit;
		bit              srgb_armed;
		file_verdict_t   due [$];
		int              errors;

		function new();
			errors = 0;
			clear();
		endfunction

		function void clear();
			foreach (head[i]) head[i] = 8'h00;
			seen       = 0;
			phase      = WALK_LENGTH;
			pos        = 0;
			chunk_len  = '0;
			ident      = '0;
			gamma      = '0;
			chrm_seen  = 1'b0;
			chrm_ok    = 1'b0;
			srgb_hit   = 1'b0;
			srgb_armed = 1'b0;
		endfunction

		// byte k of the srgb white point and primaries, big-endian words
		static function bit [7:0] chroma_byte(longint unsigned k);
			bit [31:0] w;
			case (k[4:2])
				3'd0: w = 32'd31270;
				3'd1: w = 32'd32900;
				3'd2: w = 32'd64000;
				3'd3: w = 32'd33000;
				3'd4: w = 32'd30000;
				3'd5: w = 32'd60000;
				3'd6: w = 32'd15000;
				default: w = 32'd6000;
			endcase
			return w[31 - 8 * k[1:0] -: 8];
		endfunction

		function void walk_byte(bit [7:0] b);
			case (phase)
				WALK_IDENT: begin
					ident = (pos == 0) ? {24'd0, b} : {ident[23:0], b};
					if (pos >= 3) begin
						phase      = WALK_DATA;
						pos        = 0;
						srgb_armed = (ident == ID_SRGB);
					end else begin
						pos++;
					end
				end
				WALK_DATA: begin
					if (srgb_armed)
						srgb_hit = 1'b1;
					srgb_armed = 1'b0;
					if (ident == ID_GAMA && pos < 4)
						gamma = (pos == 0) ? {24'd0, b} : {gamma[23:0], b};
					if (ident == ID_CHRM && pos < 32) begin
						if (pos == 0) begin
							chrm_seen = 1'b1;
							chrm_ok   = (b == chroma_byte(pos));
						end else if (b != chroma_byte(pos)) begin
							chrm_ok = 1'b0;
						end
					end
					pos++;
					// skip is length plus crc, no wrap
					if (pos >= {32'd0, chunk_len} + 64'd4) begin
						if (ident == ID_CHRM && pos < 32)
							chrm_ok = 1'b0;
						phase = WALK_LENGTH;
						pos   = 0;
					end
				end
				default: begin
					chunk_len = (pos == 0) ? {24'd0, b} : {chunk_len[23:0], b};
					if (pos >= 3) begin
						phase = WALK_IDENT;
						pos   = 0;
					end else begin
						phase = WALK_LENGTH;
						pos++;
					end
				end
			endcase
		endfunction

		function bit png_srgb();
			bit complete;
			complete = chrm_ok;
			if (srgb_hit)
				return 1'b1;
			if (phase == WALK_DATA && ident == ID_CHRM && pos < 32)
				complete = 1'b0;
			if (gamma == 0 || !chrm_seen)
				return 1'b0;
			if (!(gamma > GAMMA_LOW && gamma < GAMMA_HIGH))
				return 1'b0;
			return complete;
		endfunction

		function bit head_is(bit [79:0] pat, int n);
			for (int i = 0; i < n; i++)
				if (head[i] != pat[79 - 8 * i -: 8])
					return 1'b0;
			return 1'b1;
		endfunction

		function void take_byte(bit [7:0] b, bit last);
			file_verdict_t v;
			bit [31:0]     magic;
			if (seen < 10)
				head[seen] = b;
			if (seen >= 8)
				walk_byte(b);
			if (seen < 10)
				seen++;
			if (!last)
				return;
			v.kind        = KIND_UNKNOWN;
			v.color_space = SPACE_SRGB;
			if (seen >= 4) begin
				magic = {head[3], head[2], head[1], head[0]};
				if (magic == EXR_MAGIC_A || magic == EXR_MAGIC_B) begin
					v.kind        = KIND_EXR;
					v.color_space = SPACE_LINEAR;
				end
			end
			if (v.kind == KIND_UNKNOWN && seen >= 8 && head_is({PNG_SIG, 16'h0}, 8)) begin
				v.kind        = KIND_PNG;
				v.color_space = png_srgb() ? SPACE_SRGB : SPACE_LINEAR;
			end
			if (v.kind == KIND_UNKNOWN && seen >= 3 && head_is({24'hFFD8FF, 56'h0}, 3)) begin
				v.kind        = KIND_JPEG;
				v.color_space = SPACE_SRGB;
			end
			if (v.kind == KIND_UNKNOWN && seen >= 10 &&
			    (head_is(HDR_LONG, 10) || head_is({HDR_SHORT, 32'h0}, 6))) begin
				v.kind        = KIND_HDR;
				v.color_space = SPACE_LINEAR;
			end
			v.recognized = (v.kind != KIND_UNKNOWN);
			due.push_back(v);
			clear();
		endfunction

		function void check_verdict(logic [7:0] beat);
			file_verdict_t want;
			if (due.size() == 0) begin
				errors++;
				$display("%0t: result beat %h with no file pending", $time, beat);
				return;
			end
			want = due.pop_front();
			if (beat[0] !== want.recognized) begin
				errors++;
				$display("%0t: recognized expected %0d actual %0d", $time,
				         want.recognized, beat[0]);
			end
			if (beat[3:1] !== want.kind) begin
				errors++;
				$display("%0t: file_kind expected %0d actual %0d", $time, want.kind, beat[3:1]);
			end
			if (beat[4] !== want.color_space) begin
				errors++;
				$display("%0t: color_space expected %0d actual %0d", $time,
				         want.color_space, beat[4]);
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n        = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata  = 8'h00;   // data_byte[7:0]
	logic       s_axis_tlast  = 1'b0;
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;            // recognized, file_kind[2:0], color_space, zero pad

	file_verdicts_t verdicts;
	bit [7:0]       img [$];
	bit             calm;
	int             sent;
	int             files;

	image_format_sniffer_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && verdicts != null) begin
			if (s_axis_tvalid && s_axis_tready)
				verdicts.take_byte(s_axis_tdata, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready)
				verdicts.check_verdict(m_axis_tdata);
		end
	end

	// result side: stall a drawn number of cycles once a result shows up
	initial begin
		int gap;
		wait (arst_n);
		forever begin
			gap = calm ? 0 : $urandom_range(0, 3);
			if (gap != 0) begin
				m_axis_tready <= 1'b0;
				do @(posedge clk); while (!m_axis_tvalid);
				repeat (gap - 1) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	function automatic void put_bytes(bit [79:0] pat, int n);
		for (int i = 0; i < n; i++)
			img.push_back(pat[79 - 8 * i -: 8]);
	endfunction

	function automatic void put_be32(bit [31:0] w);
		for (int i = 0; i < 4; i++)
			img.push_back(w[31 - 8 * i -: 8]);
	endfunction

	// chunk header plus up to cap bytes of data and crc; spoil marks one bad data byte
	function automatic void put_chunk(bit [31:0] id, bit [31:0] len, bit [31:0] gam,
	                                  int spoil, int cap);
		longint unsigned total;
		bit [7:0]        b;
		put_be32(len);
		put_be32(id);
		total = {32'd0, len} + 64'd4;
		for (longint unsigned j = 0; j < total && j < cap; j++) begin
			b = 8'($urandom);
			if (id == ID_GAMA && j < 4)
				b = gam[31 - 8 * j -: 8];
			if (id == ID_CHRM && j < 32)
				b = file_verdicts_t::chroma_byte(j);
			if (j == spoil)
				b = b ^ (8'd1 << $urandom_range(0, 7));
			img.push_back(b);
		end
	endfunction

	function automatic void cut_short();
		int keep;
		keep = $urandom_range(1, img.size());
		while (img.size() > keep)
			void'(img.pop_back());
	endfunction

	function automatic bit [31:0] pick_gamma();
		int sel;
		sel = $urandom_range(0, 7);
		if (sel < 6)
			return GAMMA_LOW + sel;
		return (sel == 6) ? 32'd0 : $urandom();
	endfunction

	function automatic void build_png();
		int        chunks;
		int        sel;
		int        spoil;
		bit [31:0] id;
		bit [31:0] len;
		img.delete();
		put_bytes({PNG_SIG, 16'h0}, 8);
		if ($urandom_range(0, 11) == 0)
			img[$urandom_range(0, 7)] ^= 8'd1 << $urandom_range(0, 7);
		chunks = $urandom_range(0, 5);
		for (int c = 0; c < chunks; c++) begin
			sel   = $urandom_range(0, 9);
			spoil = -1;
			if (sel < 2) begin
				id  = ID_SRGB;
				len = $urandom_range(0, 3);
			end else if (sel < 4) begin
				id  = ID_GAMA;
				len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : 4;
			end else if (sel < 7) begin
				id  = ID_CHRM;
				len = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : 32;
				if ($urandom_range(0, 3) == 0)
					spoil = $urandom_range(0, 31);
			end else begin
				// unrelated chunk, sometimes one bit away from a known ident
				case ($urandom_range(0, 5))
					0: id = ID_SRGB ^ (32'd1 << $urandom_range(0, 31));
					1: id = ID_GAMA ^ (32'd1 << $urandom_range(0, 31));
					2: id = ID_CHRM ^ (32'd1 << $urandom_range(0, 31));
					default: id = $urandom();
				endcase
				len = $urandom_range(0, 12);
			end
			if ($urandom_range(0, 15) == 0) begin
				// huge length: the file ends inside this chunk
				put_chunk(id, $urandom(), pick_gamma(), spoil, $urandom_range(0, 24));
				break;
			end
			put_chunk(id, len, pick_gamma(), spoil, 64);
		end
		if ($urandom_range(0, 3) == 0)
			cut_short();
	endfunction

	function automatic void build_other();
		bit [79:0] pat;
		int        n;
		int        sel;
		img.delete();
		sel = $urandom_range(0, 6);
		case (sel)
			0: begin
				pat = {EXR_MAGIC_A[7:0], EXR_MAGIC_A[15:8], EXR_MAGIC_A[23:16],
				       EXR_MAGIC_A[31:24], 48'h0};
				n = 4;
			end
			1: begin
				pat = {EXR_MAGIC_B[7:0], EXR_MAGIC_B[15:8], EXR_MAGIC_B[23:16],
				       EXR_MAGIC_B[31:24], 48'h0};
				n = 4;
			end
			2: begin
				pat = {24'hFFD8FF, 56'h0};
				n   = 3;
			end
			3: begin
				pat = HDR_LONG;
				n   = 10;
			end
			4: begin
				pat = {HDR_SHORT, 32'h0};
				n   = 6;
			end
			default: begin
				pat = '0;
				n   = 0;
			end
		endcase
		put_bytes(pat, n);
		if (n != 0 && $urandom_range(0, 3) == 0)
			img[$urandom_range(0, n - 1)] ^= 8'd1 << $urandom_range(0, 7);
		repeat ((n == 0) ? $urandom_range(1, 20) : $urandom_range(0, 8))
			img.push_back(8'($urandom));
		if ($urandom_range(0, 4) == 0)
			cut_short();
	endfunction

	task automatic send_file();
		int gap;
		for (int i = 0; i < img.size(); i++) begin
			gap = calm ? 0 : $urandom_range(0, 3);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			s_axis_tvalid <= 1'b1;
			s_axis_tdata  <= img[i];
			s_axis_tlast  <= (i == img.size() - 1);
			do @(posedge clk); while (!s_axis_tready);
			sent++;
		end
		files++;
	endtask

	// hold the input until every pending verdict has come back
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (verdicts.due.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		verdicts = new();
		calm     = 1'b1;
		sent     = 0;
		files    = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// exr, jpeg, a one-byte file, and an srgb chunk followed by a single byte
		img.delete();
		put_bytes({EXR_MAGIC_A[7:0], EXR_MAGIC_A[15:8], EXR_MAGIC_A[23:16],
		           EXR_MAGIC_A[31:24], 48'h0}, 4);
		send_file();
		img.delete();
		put_bytes({24'hFFD8FF, 56'h0}, 3);
		send_file();
		img.delete();
		img.push_back(8'h00);
		send_file();
		img.delete();
		put_bytes({PNG_SIG, 16'h0}, 8);
		put_chunk(ID_SRGB, 32'd1, 32'd0, -1, 1);
		send_file();
		drain();

		while (sent < 1950 || files < 60) begin
			calm = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 9) < 6)
				build_png();
			else
				build_other();
			send_file();
			if (files == 30)
				drain();
		end
		drain();
		repeat (10) @(posedge clk);
		if (verdicts.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

>>> sim.f
rtl/isf_pkg.sv
rtl/isf_magic.sv
rtl/isf_chunk_walk.sv
rtl/image_format_sniffer_unit.sv
verif/image_format_sniffer_unit_tb.sv
